/* sv/iqs_pkg.sv */
// Package for the issue queue select unit: entry layout, command and opcode codes,
// queue and register-file sizes, and the operand readiness functions.
// No dependencies.
package iqs_pkg;

	localparam int QUEUE_DEPTH = 24;
	localparam int PHYS_REGS   = 48;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int CMD_W = 3;
	localparam int OP_W  = 5;
	localparam int REG_W = 6;
	localparam int PAY_W = 32;

	localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET_RDY = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLR_RDY = 3'd2;
	localparam logic [CMD_W-1:0] CMD_INT_SEL = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MUL_SEL = 3'd4;

	localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
	localparam logic [OP_W-1:0] OP_SUB   = 5'd1;
	localparam logic [OP_W-1:0] OP_AND   = 5'd2;
	localparam logic [OP_W-1:0] OP_OR    = 5'd3;
	localparam logic [OP_W-1:0] OP_EXOR  = 5'd4;
	localparam logic [OP_W-1:0] OP_LOAD  = 5'd5;
	localparam logic [OP_W-1:0] OP_STORE = 5'd6;
	localparam logic [OP_W-1:0] OP_MOVC  = 5'd7;
	localparam logic [OP_W-1:0] OP_ADDL  = 5'd8;
	localparam logic [OP_W-1:0] OP_SUBL  = 5'd9;
	localparam logic [OP_W-1:0] OP_BZ    = 5'd10;
	localparam logic [OP_W-1:0] OP_BNZ   = 5'd11;
	localparam logic [OP_W-1:0] OP_JUMP  = 5'd12;
	localparam logic [OP_W-1:0] OP_JAL   = 5'd13;
	localparam logic [OP_W-1:0] OP_CMP   = 5'd14;
	localparam logic [OP_W-1:0] OP_LDR   = 5'd15;
	localparam logic [OP_W-1:0] OP_STR   = 5'd16;
	localparam logic [OP_W-1:0] OP_MUL   = 5'd17;

	typedef logic [PHYS_REGS-1:0] ready_vec_t;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [REG_W-1:0] src_one;
		logic [REG_W-1:0] src_two;
		logic [REG_W-1:0] src_three;
		logic [REG_W-1:0] dest;
		logic [PAY_W-1:0] payload;
	} entry_t;

	// Controls shared by every cell of the queue.
	typedef struct packed {
		logic eval;
		logic int_sel;
		logic mul_sel;
		logic take;
	} cell_ctrl_t;

	// A register beyond the register file always reads as ready.
	function automatic logic reg_rdy(input ready_vec_t rv, input logic [REG_W-1:0] r);
		logic res;
		res = 1'b1;
		if (r < REG_W'(PHYS_REGS)) begin
			res = rv[r];
		end
		return res;
	endfunction

	function automatic logic int_ready(input entry_t e, input ready_vec_t rv);
		logic r1;
		logic r2;
		logic r3;
		logic res;
		r1 = reg_rdy(rv, e.src_one);
		r2 = reg_rdy(rv, e.src_two);
		r3 = reg_rdy(rv, e.src_three);
		case (e.opcode)
			OP_ADD, OP_SUB, OP_AND, OP_OR, OP_EXOR, OP_CMP, OP_LDR: res = r1 & r2;
			OP_LOAD, OP_ADDL, OP_SUBL: res = r1;
			OP_STORE: res = r2;
			OP_STR: res = r1 & r2 & r3;
			OP_MOVC, OP_BZ, OP_BNZ, OP_JUMP, OP_JAL: res = 1'b1;
			default: res = 1'b0;
		endcase
		return res;
	endfunction

	function automatic logic mul_ready(input entry_t e, input ready_vec_t rv);
		return (e.opcode == OP_MUL) & reg_rdy(rv, e.src_one) & reg_rdy(rv, e.src_two);
	endfunction

endpackage

/* sv/issue_queue_select_unit.sv */
// Top level of the issue queue select unit: request capture, the row of queue
// cells, ready bits, occupancy count and the result register.
// Depends on iqs_pkg and iqs_cell.

// The unit takes a new request only once the previous one is done: the request is
// captured, then every queue cell evaluates its own readiness against the register
// ready bits in parallel, then the oldest candidate is found by a priority chain
// that runs through the row of cells and the result is written to the output
// register. Readiness and the collapsing shift are registered in separate steps.
// A request is taken while an earlier result still waits in the output register;
// only the final step waits for that register to drain. Push, ready set and ready
// clear follow the same three steps and always return one result carrying the
// occupancy. Entries are kept oldest first in slot 0, and an issued entry is
// removed with all younger entries moving down one slot. The register ready bits
// come out of reset all ready and the queue comes out empty.
module issue_queue_select_unit
	import iqs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CMD_W-1:0] cmd,
	input  logic [OP_W-1:0]  opcode,
	input  logic [REG_W-1:0] src_one,
	input  logic [REG_W-1:0] src_two,
	input  logic [REG_W-1:0] src_three,
	input  logic [REG_W-1:0] dest,
	input  logic [PAY_W-1:0] payload,
	input  logic [REG_W-1:0] reg_index,
	input  logic             mul_stalled,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             issued,
	output logic             bubble,
	output logic [OP_W-1:0]  out_opcode,
	output logic [REG_W-1:0] out_src_one,
	output logic [REG_W-1:0] out_src_two,
	output logic [REG_W-1:0] out_src_three,
	output logic [REG_W-1:0] out_dest,
	output logic [PAY_W-1:0] out_payload,
	output logic             dropped,
	output logic [CNT_W-1:0] occupancy
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_EVAL  = 3'b010,
		S_ISSUE = 3'b100
	} state_t;

	state_t state_q;

	// Captured request.
	logic [CMD_W-1:0] req_cmd_q;
	entry_t           req_entry_q;
	logic [REG_W-1:0] req_reg_q;
	logic             req_mstall_q;

	logic [CNT_W-1:0] count_q;
	ready_vec_t       ready_q;

	logic             out_valid_q;
	logic             issued_q;
	logic             bubble_q;
	entry_t           out_entry_q;
	logic             dropped_q;
	logic [CNT_W-1:0] occ_q;

	logic                   in_fire;
	logic                   fire;
	logic                   is_push;
	logic                   full;
	logic                   push_ok;
	logic                   sel_issued;
	logic                   sel_bubble;
	entry_t                 sel_entry;
	logic [CNT_W-1:0]       count_next;
	cell_ctrl_t             ctrl;
	logic [QUEUE_DEPTH-1:0] occ;
	logic [QUEUE_DEPTH-1:0] load;
	logic [QUEUE_DEPTH-1:0] pick;
	logic [QUEUE_DEPTH:0]   prior;
	entry_t                 cell_entry [QUEUE_DEPTH];

	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid & ~in_stall;

	// The final step completes once the output register is free or being drained.
	assign fire = (state_q == S_ISSUE) & (~out_valid_q | ~out_stall);

	assign is_push = (req_cmd_q == CMD_PUSH);
	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push_ok = is_push & ~full;

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			occ[i]  = (CNT_W'(i) < count_q);
			load[i] = fire & push_ok & (count_q == CNT_W'(i));
		end
	end

	assign ctrl.eval    = (state_q == S_EVAL);
	assign ctrl.int_sel = (req_cmd_q == CMD_INT_SEL);
	assign ctrl.mul_sel = (req_cmd_q == CMD_MUL_SEL) & ~req_mstall_q;
	assign ctrl.take    = fire & sel_issued;

	// The priority chain starts clear at the oldest slot.
	assign prior[0] = 1'b0;

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		entry_t nxt;
		if (g == QUEUE_DEPTH - 1) begin : g_last
			assign nxt = cell_entry[g];
		end else begin : g_mid
			assign nxt = cell_entry[g+1];
		end

		iqs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.occ        (occ[g]),
			.load       (load[g]),
			.new_entry  (req_entry_q),
			.next_entry (nxt),
			.ready_vec  (ready_q),
			.prior_in   (prior[g]),
			.prior_out  (prior[g+1]),
			.pick       (pick[g]),
			.entry      (cell_entry[g])
		);
	end

	// The one picked cell drives the result bus; a picked free slot is a bubble.
	always_comb begin
		sel_entry  = '0;
		sel_issued = 1'b0;
		sel_bubble = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			sel_entry  = sel_entry | (cell_entry[i] & {$bits(entry_t){pick[i] & occ[i]}});
			sel_issued = sel_issued | (pick[i] & occ[i]);
			sel_bubble = sel_bubble | (pick[i] & ~occ[i]);
		end
	end

	always_comb begin
		count_next = count_q;
		if (push_ok) begin
			count_next = count_q + CNT_W'(1);
		end else if (sel_issued) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					if (fire) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_cmd_q <= CMD_PUSH;
		end else if (in_fire) begin
			req_cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_entry_q.opcode    <= opcode;
			req_entry_q.src_one   <= src_one;
			req_entry_q.src_two   <= src_two;
			req_entry_q.src_three <= src_three;
			req_entry_q.dest      <= dest;
			req_entry_q.payload   <= payload;
			req_reg_q             <= reg_index;
			req_mstall_q          <= mul_stalled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ready_q <= '1;
		end else if (fire) begin
			count_q <= count_next;
			if ((req_cmd_q == CMD_SET_RDY || req_cmd_q == CMD_CLR_RDY)
			    && req_reg_q < REG_W'(PHYS_REGS)) begin
				ready_q[req_reg_q] <= (req_cmd_q == CMD_SET_RDY);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			issued_q    <= sel_issued;
			bubble_q    <= sel_bubble;
			out_entry_q <= sel_entry;
			dropped_q   <= is_push & full;
			occ_q       <= count_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign issued        = issued_q;
	assign bubble        = bubble_q;
	assign out_opcode    = out_entry_q.opcode;
	assign out_src_one   = out_entry_q.src_one;
	assign out_src_two   = out_entry_q.src_two;
	assign out_src_three = out_entry_q.src_three;
	assign out_dest      = out_entry_q.dest;
	assign out_payload   = out_entry_q.payload;
	assign dropped       = dropped_q;
	assign occupancy     = occ_q;

endmodule

/* sv/iqs_cell.sv */
// One slot of the collapsing issue queue: holds an entry, flags itself as a select
// candidate, and takes its younger neighbor's entry when the queue closes a gap.
// Depends on iqs_pkg.
module iqs_cell
	import iqs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       occ,
	input  logic       load,
	input  entry_t     new_entry,
	input  entry_t     next_entry,
	input  ready_vec_t ready_vec,
	input  logic       prior_in,
	output logic       prior_out,
	output logic       pick,
	output entry_t     entry
);

	entry_t entry_q;
	logic   hit_q;

	// A free slot stops the integer scan, which then issues a bubble.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.eval) begin
			hit_q <= (ctrl.int_sel & (~occ | int_ready(entry_q, ready_vec)))
			       | (ctrl.mul_sel & occ & mul_ready(entry_q, ready_vec));
		end
	end

	assign pick      = hit_q & ~prior_in;
	assign prior_out = prior_in | hit_q;

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= new_entry;
		end else if (ctrl.take && prior_out) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

/* tb/sv/issue_queue_select_unit_test.sv */
// Self-checking testbench for issue_queue_select_unit: directed, full-queue and random
// request streams are checked against a predictor of the collapsing issue queue.
// Depends on iqs_pkg and issue_queue_select_unit.
module issue_queue_select_unit_test;
	import iqs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Codes that the package does not name. HALT and the codes above it are never
	// picked by either select, and commands above multiply select do nothing.
	localparam logic [OP_W-1:0]  OP_HALT         = 5'd18;
	localparam logic [OP_W-1:0]  OP_LAST_CODE    = 5'd31;
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
	localparam logic [REG_W-1:0] REG_LAST_CODE   = 6'd63;
	// Last register of the register file and the first code past it.
	localparam logic [REG_W-1:0] REG_LAST_PHYS   = REG_W'(PHYS_REGS - 1);
	localparam logic [REG_W-1:0] REG_PAST_PHYS   = REG_W'(PHYS_REGS);

	localparam int REQUESTS_PER_PHASE = 123;
	localparam int EPISODE_LEN        = 23;
	localparam int DRAIN_CYCLES       = 12;

	// One request as it goes into the unit.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		entry_t           ent;
		logic [REG_W-1:0] reg_index;
		logic             mul_stalled;
	} issue_request_t;

	// One result as it comes out of the unit.
	typedef struct packed {
		logic             issued;
		logic             bubble;
		entry_t           ent;
		logic             dropped;
		logic [CNT_W-1:0] occupancy;
	} select_result_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [CMD_W-1:0] cmd;
	logic [OP_W-1:0]  opcode;
	logic [REG_W-1:0] src_one;
	logic [REG_W-1:0] src_two;
	logic [REG_W-1:0] src_three;
	logic [REG_W-1:0] dest;
	logic [PAY_W-1:0] payload;
	logic [REG_W-1:0] reg_index;
	logic             mul_stalled;
	logic             out_valid;
	logic             out_stall;
	logic             issued;
	logic             bubble;
	logic [OP_W-1:0]  out_opcode;
	logic [REG_W-1:0] out_src_one;
	logic [REG_W-1:0] out_src_two;
	logic [REG_W-1:0] out_src_three;
	logic [REG_W-1:0] out_dest;
	logic [PAY_W-1:0] out_payload;
	logic             dropped;
	logic [CNT_W-1:0] occupancy;

	// Shadow copy of the queue (slot 0 is the oldest) and of the register ready bits.
	entry_t               shadow_queue[$];
	bit [PHYS_REGS-1:0]   shadow_ready;
	select_result_t       expected_results[$];

	// Idling knobs, in percent, changed from phase to phase.
	int                   sender_idle_pct;
	int                   receiver_stall_pct;
	// Registers that random requests favor, so that clears and sets hit live sources.
	int                   hot_base;
	bit                   any_failure;

	issue_queue_select_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.opcode       (opcode),
		.src_one      (src_one),
		.src_two      (src_two),
		.src_three    (src_three),
		.dest         (dest),
		.payload      (payload),
		.reg_index    (reg_index),
		.mul_stalled  (mul_stalled),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.issued       (issued),
		.bubble       (bubble),
		.out_opcode   (out_opcode),
		.out_src_one  (out_src_one),
		.out_src_two  (out_src_two),
		.out_src_three(out_src_three),
		.out_dest     (out_dest),
		.out_payload  (out_payload),
		.dropped      (dropped),
		.occupancy    (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A register outside the register file always counts as ready.
	function automatic bit operand_ready(input logic [REG_W-1:0] r);
		return (r >= PHYS_REGS) || shadow_ready[r];
	endfunction

	// Whether integer select may take this entry; MUL, HALT and unknown codes never.
	function automatic bit int_issuable(input entry_t e);
		bit ok;
		case (e.opcode)
			OP_ADD, OP_SUB, OP_AND, OP_OR, OP_EXOR, OP_CMP, OP_LDR:
				ok = operand_ready(e.src_one) && operand_ready(e.src_two);
			OP_LOAD, OP_ADDL, OP_SUBL: ok = operand_ready(e.src_one);
			OP_STORE: ok = operand_ready(e.src_two);
			OP_STR: begin
				ok = operand_ready(e.src_one) && operand_ready(e.src_two)
					&& operand_ready(e.src_three);
			end
			OP_MOVC, OP_BZ, OP_BNZ, OP_JUMP, OP_JAL: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	// Applies one accepted request to the shadow state and returns the result the
	// unit has to produce for it.
	function automatic select_result_t predict_select_result(input issue_request_t req);
		select_result_t res;
		int pick;
		res = '0;
		pick = -1;
		case (req.cmd)
			CMD_PUSH: begin
				if (shadow_queue.size() >= QUEUE_DEPTH) begin
					res.dropped = 1'b1;
				end else begin
					shadow_queue.push_back(req.ent);
				end
			end
			CMD_SET_RDY, CMD_CLR_RDY: begin
				if (req.reg_index < PHYS_REGS) begin
					shadow_ready[req.reg_index] = (req.cmd == CMD_SET_RDY);
				end
			end
			CMD_INT_SEL: begin
				// Oldest first; a free slot ends the scan with a bubble, while a full
				// queue with nothing ready ends it with neither.
				for (int i = 0; i < QUEUE_DEPTH; i++) begin
					if (i >= shadow_queue.size()) begin
						res.bubble = 1'b1;
						break;
					end
					if (int_issuable(shadow_queue[i])) begin
						pick = i;
						break;
					end
				end
			end
			CMD_MUL_SEL: begin
				if (!req.mul_stalled) begin
					for (int i = 0; i < shadow_queue.size(); i++) begin
						if (shadow_queue[i].opcode == OP_MUL
							&& operand_ready(shadow_queue[i].src_one)
							&& operand_ready(shadow_queue[i].src_two)) begin
							pick = i;
							break;
						end
					end
				end
			end
			default: ;
		endcase
		if (pick >= 0) begin
			res.issued = 1'b1;
			res.ent = shadow_queue[pick];
			// Younger entries close the gap.
			shadow_queue.delete(pick);
		end
		res.occupancy = CNT_W'(shadow_queue.size());
		return res;
	endfunction

	function automatic issue_request_t make_push(input logic [OP_W-1:0] op,
		input logic [REG_W-1:0] s1, input logic [REG_W-1:0] s2,
		input logic [REG_W-1:0] s3, input logic [REG_W-1:0] d,
		input logic [PAY_W-1:0] pay);
		issue_request_t req;
		req = '0;
		req.cmd = CMD_PUSH;
		req.ent.opcode = op;
		req.ent.src_one = s1;
		req.ent.src_two = s2;
		req.ent.src_three = s3;
		req.ent.dest = d;
		req.ent.payload = pay;
		return req;
	endfunction

	function automatic issue_request_t make_ctrl(input logic [CMD_W-1:0] c,
		input logic [REG_W-1:0] idx, input logic stalled);
		issue_request_t req;
		req = '0;
		req.cmd = c;
		req.reg_index = idx;
		req.mul_stalled = stalled;
		return req;
	endfunction

	// Mostly the hot window, sometimes any register, now and then a code past the
	// register file, which reads as ready.
	function automatic logic [REG_W-1:0] random_reg();
		logic [REG_W-1:0] r;
		case ($urandom_range(9))
			0: r = REG_W'($urandom_range(REG_LAST_CODE));
			1, 2, 3: r = REG_W'($urandom_range(PHYS_REGS - 1));
			default: r = REG_W'(hot_base + $urandom_range(7));
		endcase
		return r;
	endfunction

	function automatic logic [OP_W-1:0] random_opcode();
		int roll;
		logic [OP_W-1:0] op;
		roll = $urandom_range(99);
		if (roll < 20) begin
			op = OP_MUL;
		end else if (roll < 26) begin
			op = OP_W'($urandom_range(OP_HALT, OP_LAST_CODE));
		end else begin
			op = OP_W'($urandom_range(OP_ADD, OP_STR));
		end
		return op;
	endfunction

	// Random request; push_weight is the percentage of pushes. The entry fields are
	// filled for every command so that ignored fields toggle too.
	function automatic issue_request_t random_request(input int push_weight);
		issue_request_t req;
		req.ent.opcode = random_opcode();
		req.ent.src_one = random_reg();
		req.ent.src_two = random_reg();
		req.ent.src_three = random_reg();
		req.ent.dest = random_reg();
		req.ent.payload = $urandom;
		req.reg_index = random_reg();
		req.mul_stalled = ($urandom_range(99) < 30);
		if ($urandom_range(99) < push_weight) begin
			req.cmd = CMD_PUSH;
		end else begin
			case ($urandom_range(19))
				0, 1, 2, 3: req.cmd = CMD_SET_RDY;
				4, 5, 6: req.cmd = CMD_CLR_RDY;
				7, 8, 9, 10, 11, 12: req.cmd = CMD_INT_SEL;
				13, 14, 15, 16, 17: req.cmd = CMD_MUL_SEL;
				default: req.cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
			endcase
		end
		return req;
	endfunction

	// Sends one request. It is called in the time step of a rising edge, optionally
	// idles the sender, then holds the request until the unit takes it. The
	// expectation is recorded at the accepting edge, so the order always matches.
	task automatic send_request(input issue_request_t req);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= req.cmd;
		opcode <= req.ent.opcode;
		src_one <= req.ent.src_one;
		src_two <= req.ent.src_two;
		src_three <= req.ent.src_three;
		dest <= req.ent.dest;
		payload <= req.ent.payload;
		reg_index <= req.reg_index;
		mul_stalled <= req.mul_stalled;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		expected_results.push_back(predict_select_result(req));
	endtask

	// Walks the special cases on a nearly empty queue: bubbles on an empty queue,
	// out-of-range ready indexes and sources, the STORE and STR source rules, a
	// stalled multiply unit, skipped HALT and unknown codes, and an unused command.
	task automatic test_directed_cases();
		send_request(make_ctrl(CMD_INT_SEL, '0, 1'b0));
		send_request(make_ctrl(CMD_MUL_SEL, '0, 1'b0));
		send_request(make_ctrl(CMD_CLR_RDY, '0, 1'b0));
		send_request(make_ctrl(CMD_CLR_RDY, REG_LAST_PHYS, 1'b0));
		send_request(make_ctrl(CMD_CLR_RDY, REG_LAST_CODE, 1'b1));
		send_request(make_ctrl(CMD_SET_RDY, REG_LAST_CODE, 1'b1));
		send_request(make_push(OP_MUL, '0, REG_LAST_PHYS, REG_LAST_CODE, REG_LAST_CODE, '1));
		send_request(make_push(OP_STR, REG_LAST_CODE, REG_PAST_PHYS, '0, '0, '0));
		// STORE waits only on its second source, so the cleared first source is no bar.
		send_request(make_push(OP_STORE, '0, REG_PAST_PHYS, '0, REG_LAST_PHYS, 32'h8000_0001));
		send_request(make_push(OP_HALT, '0, '0, '0, '0, '1));
		send_request(make_push(OP_LOAD, REG_LAST_PHYS, '0, '0, 6'd1, 32'h7fff_fffe));
		send_request(make_ctrl(CMD_INT_SEL, '0, 1'b0));
		// Nothing ready now, and the scan runs into the free slot after LOAD.
		send_request(make_ctrl(CMD_INT_SEL, '0, 1'b0));
		send_request(make_ctrl(CMD_MUL_SEL, '0, 1'b0));
		send_request(make_ctrl(CMD_SET_RDY, '0, 1'b0));
		send_request(make_ctrl(CMD_SET_RDY, REG_LAST_PHYS, 1'b0));
		send_request(make_ctrl(CMD_MUL_SEL, '0, 1'b1));
		send_request(make_ctrl(CMD_MUL_SEL, '0, 1'b0));
		send_request(make_ctrl(CMD_INT_SEL, '0, 1'b0));
		send_request(make_ctrl(CMD_INT_SEL, '0, 1'b0));
		send_request(make_ctrl(CMD_SPARE_LAST, '0, 1'b1));
		send_request(make_push(OP_LAST_CODE, '0, '0, '0, '0, '0));
		send_request(make_ctrl(CMD_INT_SEL, '0, 1'b0));
	endtask

	// Fills the queue with entries that all wait on one cleared register, so that a
	// further push is dropped and integer select on a full queue finds nothing and
	// gives no bubble. Releasing the register then lets the queue drain in part.
	task automatic test_full_queue();
		logic [REG_W-1:0] blocker;
		issue_request_t req;
		blocker = REG_W'($urandom_range(PHYS_REGS - 1));
		send_request(make_ctrl(CMD_CLR_RDY, blocker, 1'b0));
		while (shadow_queue.size() < QUEUE_DEPTH) begin
			do begin
				req = make_push(random_opcode(), blocker, blocker, blocker, random_reg(),
					$urandom);
			end while (int_issuable(req.ent));
			send_request(req);
		end
		send_request(make_push(OP_MOVC, '0, '0, '0, '0, $urandom));
		send_request(make_ctrl(CMD_INT_SEL, '0, 1'b0));
		send_request(make_ctrl(CMD_MUL_SEL, '0, 1'b0));
		send_request(make_ctrl(CMD_SET_RDY, blocker, 1'b0));
		repeat (6) send_request(make_ctrl(CMD_INT_SEL, '0, 1'b0));
		send_request(make_ctrl(CMD_MUL_SEL, '0, 1'b0));
	endtask

	// Random traffic in four idling phases. Each phase is cut into episodes with
	// their own push rate and hot register window, so the queue swings between
	// empty and full while readiness keeps changing under it.
	task automatic test_random_traffic();
		int idle_plan[4];
		int stall_plan[4];
		int push_weight;
		idle_plan = '{0, 50, 0, 37};
		stall_plan = '{0, 0, 50, 37};
		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct = idle_plan[phase];
			receiver_stall_pct = stall_plan[phase];
			for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
				if (n % EPISODE_LEN == 0) begin
					case ($urandom_range(2))
						0: push_weight = 25;
						1: push_weight = 45;
						default: push_weight = 70;
					endcase
					hot_base = $urandom_range(PHYS_REGS - 8);
				end
				send_request(random_request(push_weight));
			end
		end
	endtask

	// The receiver stalls at random with the probability of the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	task automatic check_field(input string name, input logic [PAY_W-1:0] want,
		input logic [PAY_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			any_failure = 1'b1;
		end
	endtask

	// Every result taken from the unit is matched with the oldest expectation.
	always @(posedge clk) begin : result_check
		select_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				$error("result with no request waiting for it");
				any_failure = 1'b1;
			end else begin
				want = expected_results.pop_front();
				check_field("issued", PAY_W'(want.issued), PAY_W'(issued));
				check_field("bubble", PAY_W'(want.bubble), PAY_W'(bubble));
				check_field("out_opcode", PAY_W'(want.ent.opcode), PAY_W'(out_opcode));
				check_field("out_src_one", PAY_W'(want.ent.src_one), PAY_W'(out_src_one));
				check_field("out_src_two", PAY_W'(want.ent.src_two), PAY_W'(out_src_two));
				check_field("out_src_three", PAY_W'(want.ent.src_three),
					PAY_W'(out_src_three));
				check_field("out_dest", PAY_W'(want.ent.dest), PAY_W'(out_dest));
				check_field("out_payload", want.ent.payload, out_payload);
				check_field("dropped", PAY_W'(want.dropped), PAY_W'(dropped));
				check_field("occupancy", PAY_W'(want.occupancy), PAY_W'(occupancy));
			end
		end
	end

	initial begin
		any_failure = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hot_base = 0;
		shadow_ready = '1;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		out_stall <= 1'b0;
		cmd <= CMD_PUSH;
		opcode <= OP_ADD;
		src_one <= '0;
		src_two <= '0;
		src_three <= '0;
		dest <= '0;
		payload <= '0;
		reg_index <= '0;
		mul_stalled <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_full_queue();
		test_random_traffic();

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		// Keep the clock running so that any result that should not be there still shows.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!any_failure) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Hard stop: far beyond the slowest correct run of roughly 550 requests.
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
sv/iqs_pkg.sv
sv/iqs_cell.sv
sv/issue_queue_select_unit.sv
tb/sv/issue_queue_select_unit_test.sv
